// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the starfield checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMP(lbl, ck, rn, ant, con) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (con)) \
        else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NXT(lbl, ck, rn, ant, con) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (con)) \
        else $error("assertion failed");

`endif

// File: hdl/sfpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_pkg
// Types and constants shared by the starfield project-and-advance block.
// ----------------------------------------------------------------------------
package sfpa_pkg;

    localparam int NUM_STARS_DEF = 1024;
    localparam int OFIFO_DEPTH   = 32;

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_STEP = 1'b1;

    localparam logic [16:0] Z_ONE   = 17'h10000;
    localparam logic [5:0]  DT_MAX  = 6'd32;
    // 51 * 2^32: 255 * 0.2 in the Q.16 squared depth scale
    localparam logic [41:0] BRIGHT_NUM = 42'd51 << 32;

    localparam logic [9:0] W_RESET = 10'd320;
    localparam logic [9:0] H_RESET = 10'd256;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0]        z;
    } star_t;

    // star as read for one step, handed from memory stage to datapath
    typedef struct packed {
        logic               step;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [16:0]        z;
    } item_t;

    typedef struct packed {
        logic       vis;
        logic [7:0] br;
        logic [9:0] py;
        logic [9:0] px;
    } result_t;

endpackage

// File: hdl/sfpa_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_mem
// Star memory with read-modify-write of depth and write-back forwarding.
// ----------------------------------------------------------------------------
module sfpa_mem #(
    parameter int NUM_STARS = sfpa_pkg::NUM_STARS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_vld,
    input  logic                op,
    input  logic [9:0]          idx,
    input  sfpa_pkg::star_t     ld,
    input  logic [5:0]          dt,
    output logic                item_vld,
    output sfpa_pkg::item_t     item
);
    import sfpa_pkg::*;

    localparam int AW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;

    star_t            mem [NUM_STARS];
    star_t            rd_data_reg;

    logic             s1_vld_reg;
    logic             s1_op_reg;
    logic             s1_inr_reg;
    logic [AW-1:0]    s1_addr_reg;
    star_t            s1_ld_reg;
    logic [5:0]       s1_dt_reg;

    logic             wb_vld_reg;
    logic [AW-1:0]    wb_addr_reg;
    star_t            wb_data_reg;

    logic [AW-1:0]    rd_addr;
    logic             inr;
    star_t            ld_clamp;
    logic [5:0]       dt_sat;
    star_t            cur;
    logic signed [18:0] nz_s;
    logic [16:0]      nz;
    logic             wr_en;
    star_t            wr_data;

    assign rd_addr = AW'(idx);
    assign inr     = (32'(idx) < NUM_STARS);

    // clamp depth and time on the way in
    always_comb
    begin
        ld_clamp = ld;
        if (ld.z == 17'd0)
        begin
            ld_clamp.z = 17'd1;
        end
        else if (ld.z > Z_ONE)
        begin
            ld_clamp.z = Z_ONE;
        end
        dt_sat = (dt > DT_MAX) ? DT_MAX : dt;
    end

    // memory array: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            wb_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            wb_vld_reg <= wr_en;
        end
    end

    // stage 1 payload and last write
    always_ff @(posedge clk)
    begin
        s1_op_reg   <= op;
        s1_inr_reg  <= inr;
        s1_addr_reg <= rd_addr;
        s1_ld_reg   <= ld_clamp;
        s1_dt_reg   <= dt_sat;
        wb_addr_reg <= s1_addr_reg;
        wb_data_reg <= wr_data;
    end

    // forward the write that landed on the same edge as our read
    assign cur = (wb_vld_reg && (wb_addr_reg == s1_addr_reg)) ? wb_data_reg : rd_data_reg;

    // depth advance with wrap into 1..65536
    always_comb
    begin
        nz_s = $signed(19'(cur.z)) - $signed(19'({s1_dt_reg, 11'd0}));
        if (nz_s <= 19'sd0)
        begin
            nz_s = nz_s + 19'sd65536;
        end
        if (nz_s > 19'sd65536)
        begin
            nz_s = nz_s - 19'sd65536;
        end
        nz = nz_s[16:0];
    end

    assign wr_en = s1_vld_reg && s1_inr_reg;

    always_comb
    begin
        if (s1_op_reg == OP_LOAD)
        begin
            wr_data = s1_ld_reg;
        end
        else
        begin
            wr_data   = cur;
            wr_data.z = nz;
        end
    end

    assign item_vld  = s1_vld_reg;
    assign item.step = (s1_op_reg == OP_STEP) && s1_inr_reg;
    assign item.x    = cur.x;
    assign item.y    = cur.y;
    assign item.z    = cur.z;

endmodule

// File: hdl/sfpa_proj.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_proj
// Projection pipeline: products, then bit-per-stage restoring division.
// ----------------------------------------------------------------------------
module sfpa_proj (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_vld,
    input  sfpa_pkg::item_t   item,
    input  logic [9:0]        scr_w,
    input  logic [9:0]        scr_h,
    output logic              res_vld,
    output sfpa_pkg::result_t res
);
    import sfpa_pkg::*;

    localparam int QB = 11;
    localparam int BB = 8;

    typedef struct packed {
        logic        step;
        logic        nx;
        logic        ny;
        logic        ov;
        logic        bsat;
        logic [27:0] rx;
        logic [27:0] ry;
        logic [QB-1:0] qx;
        logic [QB-1:0] qy;
        logic [16:0] z;
        logic [33:0] d2;
        logic [41:0] brem;
        logic [BB-1:0] bq;
    } div_t;

    // products stage
    logic               a_vld_reg;
    logic               a_step_reg;
    logic signed [26:0] a_px_reg;
    logic signed [26:0] a_py_reg;
    logic [16:0]        a_z_reg;
    logic [33:0]        a_d2_reg;

    logic               dv_vld_reg [QB+1];
    div_t               dv_reg     [QB+1];

    div_t               d0;
    logic [26:0]        mx;
    logic [26:0]        my;
    logic [27:0]        zlim;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= item_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        a_step_reg <= item.step;
        a_px_reg   <= $signed({1'b0, scr_h}) * item.x;
        a_py_reg   <= $signed({1'b0, scr_h}) * item.y;
        a_z_reg    <= item.z;
        a_d2_reg   <= item.z * item.z;
    end

    // magnitudes, overflow and saturation checks
    always_comb
    begin
        mx      = a_px_reg[26] ? 27'(-a_px_reg) : 27'(a_px_reg);
        my      = a_py_reg[26] ? 27'(-a_py_reg) : 27'(a_py_reg);
        zlim    = 28'(a_z_reg) << QB;
        d0.step = a_step_reg;
        d0.nx   = a_px_reg[26];
        d0.ny   = a_py_reg[26];
        d0.ov   = (28'(mx) >= zlim) || (28'(my) >= zlim);
        d0.bsat = BRIGHT_NUM >= (42'(a_d2_reg) << BB);
        d0.rx   = 28'(mx);
        d0.ry   = 28'(my);
        d0.qx   = '0;
        d0.qy   = '0;
        d0.z    = a_z_reg;
        d0.d2   = a_d2_reg;
        d0.brem = BRIGHT_NUM;
        d0.bq   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else
        begin
            dv_vld_reg[0] <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_reg[0] <= d0;
    end

    // one quotient bit per stage; brightness rides along in the first stages
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        div_t        dn;
        logic [27:0] zs;
        logic [41:0] ds;

        always_comb
        begin
            dn = dv_reg[k];
            zs = 28'(dv_reg[k].z) << (QB - 1 - k);
            ds = 42'(dv_reg[k].d2) << ((k < BB) ? (BB - 1 - k) : 0);
            if (dv_reg[k].rx >= zs)
            begin
                dn.rx            = dv_reg[k].rx - zs;
                dn.qx[QB - 1 - k] = 1'b1;
            end
            if (dv_reg[k].ry >= zs)
            begin
                dn.ry            = dv_reg[k].ry - zs;
                dn.qy[QB - 1 - k] = 1'b1;
            end
            if ((k < BB) && (dv_reg[k].brem >= ds))
            begin
                dn.brem = dv_reg[k].brem - ds;
                dn.bq[(k < BB) ? (BB - 1 - k) : 0] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_reg[k+1] <= dn;
        end
    end

    // floor for negatives, recenter and clip
    div_t               df;
    logic signed [12:0] ux;
    logic signed [12:0] vy;
    logic               vis;

    assign df = dv_reg[QB];

    always_comb
    begin
        ux = df.nx ? -(13'(df.qx) + 13'(df.rx != '0)) : 13'(df.qx);
        vy = df.ny ? -(13'(df.qy) + 13'(df.ry != '0)) : 13'(df.qy);
        ux = ux + 13'(scr_w >> 1);
        vy = vy + 13'(scr_h >> 1);
        vis = df.step && !df.ov && !ux[12] && !vy[12]
              && (ux < $signed(13'(scr_w))) && (vy < $signed(13'(scr_h)));
        res.vis = vis;
        res.px  = vis ? ux[9:0] : 10'd0;
        res.py  = vis ? vy[9:0] : 10'd0;
        if (!df.step)
        begin
            res.br = '0;
        end
        else
        begin
            res.br = df.bsat ? 8'd255 : df.bq;
        end
    end

    assign res_vld = dv_vld_reg[QB];

endmodule

// File: hdl/sfpa_ofifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_ofifo
// Output queue that absorbs every result in flight while the sink stalls.
// ----------------------------------------------------------------------------
module sfpa_ofifo #(
    parameter int DEPTH = sfpa_pkg::OFIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  sfpa_pkg::result_t wr_data,
    input  logic              rd_en,
    output logic              not_empty,
    output sfpa_pkg::result_t rd_data
);
    import sfpa_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    result_t       q [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   cnt_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers wrap at DEPTH
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(wr_en) - (PW+1)'(rd_en);
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign rd_data   = q[rd_ptr_reg];

endmodule

// File: hdl/starfield_project_and_advance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// starfield_project_and_advance
// Perspective starfield: loads stars, projects one and advances its depth.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tuser=op; tdata=index,x,y,z,elapsed_ms
// m_*      out  tvalid/tready      tuser=visible; tdata=pixel_x,pixel_y,brightness
// cfg_*    in   cfg_we             cfg_addr 0=width 1=height, cfg_wdata
//
// One item per cycle sustained while s_tready is high; an item passes the memory,
// product and check stages, then the 11-stage quotient pipeline, before the write
// into the output queue.
// Depth read-modify-write completes in the cycle after the transfer, with forwarding.
// A 32-entry output queue holds results; s_tready drops once 32 items are
// accepted and not yet delivered. No clearing pass after reset.
// ----------------------------------------------------------------------------
module starfield_project_and_advance #(
    parameter int NUM_STARS = sfpa_pkg::NUM_STARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // star_index[9:0], star_x[25:10], star_y[41:26],
                                   // star_z[58:42], elapsed_ms[64:59], zero fill
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pixel_x[9:0], pixel_y[19:10], brightness[27:20]
    output logic        m_tuser,   // visible
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [9:0]  cfg_wdata
);
    import sfpa_pkg::*;

    localparam int OW = $clog2(OFIFO_DEPTH + 1);

    logic [9:0]  scr_w_reg;
    logic [9:0]  scr_h_reg;
    logic [OW-1:0] occ_reg;

    logic        s_xfer;
    logic        m_xfer;
    star_t       ld;
    logic        item_vld;
    item_t       item;
    logic        res_vld;
    result_t     res;
    result_t     head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= W_RESET;
            scr_h_reg <= H_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_WIDTH:  scr_w_reg <= cfg_wdata;
                CFG_HEIGHT: scr_h_reg <= cfg_wdata;
                default:    scr_w_reg <= scr_w_reg;
            endcase
        end
    end

    // items accepted and not yet delivered
    assign s_tready = (32'(occ_reg) < OFIFO_DEPTH);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_reg + OW'(s_xfer) - OW'(m_xfer);
        end
    end

    assign ld.x = s_tdata[25:10];
    assign ld.y = s_tdata[41:26];
    assign ld.z = s_tdata[58:42];

    sfpa_mem #(
        .NUM_STARS (NUM_STARS)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s_xfer),
        .op       (s_tuser),
        .idx      (s_tdata[9:0]),
        .ld       (ld),
        .dt       (s_tdata[64:59]),
        .item_vld (item_vld),
        .item     (item)
    );

    sfpa_proj u_proj (
        .clk      (clk),
        .rst_n    (rst_n),
        .item_vld (item_vld),
        .item     (item),
        .scr_w    (scr_w_reg),
        .scr_h    (scr_h_reg),
        .res_vld  (res_vld),
        .res      (res)
    );

    sfpa_ofifo #(
        .DEPTH (OFIFO_DEPTH)
    ) u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (res_vld),
        .wr_data   (res),
        .rd_en     (m_xfer),
        .not_empty (m_tvalid),
        .rd_data   (head)
    );

    assign m_tdata = {4'd0, head.br, head.py, head.px};
    assign m_tuser = head.vis;

endmodule

// File: hdl/sfpa_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpa_check
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfpa_check (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);
    // stalled result stays offered
    `ASSERT_NXT(a_hold_vld, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NXT(a_hold_dat, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))

    // off-screen and load results carry no pixel
    `ASSERT_IMP(a_zero_pix, clk, rst_n, m_tvalid && !m_tuser, m_tdata[19:0] == 20'd0)

    // any on-screen star has depth at most one, so at least 51 brightness
    `ASSERT_IMP(a_min_br, clk, rst_n, m_tvalid && m_tuser, m_tdata[27:20] >= 8'd51)

endmodule

bind starfield_project_and_advance sfpa_check u_chk (.*);
